// ===== src/jdi_pkg.sv =====
// Package for the dequantizing 8x8 inverse DCT: types, constants, weight function.
// Used by jdi_ctrl, jdi_datapath and jpeg_dequant_idct_8x8; depends on nothing.
package jdi_pkg;

  localparam int WeightFracBitsDefault = 12;
  localparam int TableBits = 24;
  localparam int ProductWidth = 28;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROW,
    ST_COL
  } jdi_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       store_write;   // write the product of the accepted request
    logic [5:0] store_addr;    // natural position for the write
    logic       row_mac;       // one row-pass multiply-accumulate
    logic       col_mac;       // one column-pass multiply-accumulate
    logic [2:0] idx_a;         // row v (row pass) or output row y (column pass)
    logic [2:0] idx_b;         // output column x
    logic [2:0] idx_k;         // summation index u or v
    logic       first;         // first term of a sum
    logic       last;          // last term of a sum
  } jdi_cmd_t;

  function automatic logic [5:0] zz_to_nat(input logic [5:0] idx);
    logic [5:0] r;
    unique case (idx)
      6'd0: r = 6'd0;   6'd1: r = 6'd1;   6'd2: r = 6'd8;   6'd3: r = 6'd16;
      6'd4: r = 6'd9;   6'd5: r = 6'd2;   6'd6: r = 6'd3;   6'd7: r = 6'd10;
      6'd8: r = 6'd17;  6'd9: r = 6'd24;  6'd10: r = 6'd32; 6'd11: r = 6'd25;
      6'd12: r = 6'd18; 6'd13: r = 6'd11; 6'd14: r = 6'd4;  6'd15: r = 6'd5;
      6'd16: r = 6'd12; 6'd17: r = 6'd19; 6'd18: r = 6'd26; 6'd19: r = 6'd33;
      6'd20: r = 6'd40; 6'd21: r = 6'd48; 6'd22: r = 6'd41; 6'd23: r = 6'd34;
      6'd24: r = 6'd27; 6'd25: r = 6'd20; 6'd26: r = 6'd13; 6'd27: r = 6'd6;
      6'd28: r = 6'd7;  6'd29: r = 6'd14; 6'd30: r = 6'd21; 6'd31: r = 6'd28;
      6'd32: r = 6'd35; 6'd33: r = 6'd42; 6'd34: r = 6'd49; 6'd35: r = 6'd56;
      6'd36: r = 6'd57; 6'd37: r = 6'd50; 6'd38: r = 6'd43; 6'd39: r = 6'd36;
      6'd40: r = 6'd29; 6'd41: r = 6'd22; 6'd42: r = 6'd15; 6'd43: r = 6'd23;
      6'd44: r = 6'd30; 6'd45: r = 6'd37; 6'd46: r = 6'd44; 6'd47: r = 6'd51;
      6'd48: r = 6'd58; 6'd49: r = 6'd59; 6'd50: r = 6'd52; 6'd51: r = 6'd45;
      6'd52: r = 6'd38; 6'd53: r = 6'd31; 6'd54: r = 6'd39; 6'd55: r = 6'd46;
      6'd56: r = 6'd53; 6'd57: r = 6'd60; 6'd58: r = 6'd61; 6'd59: r = 6'd54;
      6'd60: r = 6'd47; 6'd61: r = 6'd55; 6'd62: r = 6'd62; default: r = 6'd63;
    endcase
    return r;
  endfunction

  // Magnitude of 0.5*cos(m*pi/16) at 24 fraction bits for m = 1..7; m = 0 gives the DC weight 0.5/sqrt(2).
  function automatic logic [22:0] half_cos_q24(input logic [3:0] m);
    logic [22:0] r;
    unique case (m)
      4'd0: r = 23'd5931642;
      4'd1: r = 23'd8227423;
      4'd2: r = 23'd7750063;
      4'd3: r = 23'd6974873;
      4'd4: r = 23'd5931642;
      4'd5: r = 23'd4660461;
      4'd6: r = 23'd3210181;
      4'd7: r = 23'd1636536;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

  // Signed weight for frequency k and sample n, rounded to frac_bits fraction bits.
  // The result fits in 16 signed bits for every fraction width up to 14.
  function automatic logic signed [15:0] weight(input logic [2:0] k, input logic [2:0] n,
                                                input int frac_bits);
    logic [4:0]  m;
    logic [3:0]  mm;
    logic        neg;
    logic [23:0] mag;
    logic [23:0] rnd;
    m   = 5'((({2'b0, n} << 1) + 5'd1) * {2'b0, k});
    neg = 1'b0;
    if (k == 3'd0) begin
      mm = 4'd0;
    end else begin
      if (m > 5'd16) m = 5'd0 - m;
      if (m > 5'd8) begin
        neg = 1'b1;
        m   = 5'd16 - m;
      end
      mm = m[3:0];
    end
    rnd = 24'd1 << (TableBits - frac_bits - 1);
    mag = ({1'b0, half_cos_q24(mm)} + rnd) >> (TableBits - frac_bits);
    return neg ? -$signed(mag[15:0]) : $signed(mag[15:0]);
  endfunction

endpackage

// ===== src/jdi_ctrl.sv =====
// Controller for the dequantizing inverse DCT: loads 64 requests, then sequences
// both transform passes on the shared MAC. Depends on jdi_pkg.
module jdi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output jdi_pkg::jdi_cmd_t cmd
);

  jdi_pkg::jdi_state_t state, state_next;
  logic [5:0] arrival_count, arrival_count_next;
  logic [8:0] step, step_next;   // {a, b, k}

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= jdi_pkg::ST_LOAD;
      arrival_count <= 6'd0;
      step          <= 9'd0;
    end else begin
      state         <= state_next;
      arrival_count <= arrival_count_next;
      step          <= step_next;
    end
  end

  always_comb begin
    state_next         = state;
    arrival_count_next = arrival_count;
    step_next          = step;
    busy               = 1'b1;
    cmd                = '0;
    cmd.store_addr     = jdi_pkg::zz_to_nat(arrival_count);
    cmd.idx_a          = step[8:6];
    cmd.idx_b          = step[5:3];
    cmd.idx_k          = step[2:0];
    cmd.first          = (step[2:0] == 3'd0);
    cmd.last           = (step[2:0] == 3'd7);
    unique case (state)
      jdi_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          cmd.store_write    = 1'b1;
          arrival_count_next = arrival_count + 6'd1;
          if (arrival_count == 6'd63) begin
            state_next = jdi_pkg::ST_ROW;
            step_next  = 9'd0;
          end
        end
      end
      jdi_pkg::ST_ROW: begin
        cmd.row_mac = 1'b1;
        step_next   = step + 9'd1;
        if (step == 9'd511) state_next = jdi_pkg::ST_COL;
      end
      jdi_pkg::ST_COL: begin
        cmd.col_mac = 1'b1;
        step_next   = step + 9'd1;
        if (step == 9'd511) state_next = jdi_pkg::ST_LOAD;
      end
      default: state_next = jdi_pkg::ST_LOAD;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.store_write |-> !busy) else $error("store write while busy");
  a_one_mode: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.store_write, cmd.row_mac, cmd.col_mac})) else $error("two modes at once");
  a_count_in_load: assert property (@(posedge clk) disable iff (rst)
    (state != jdi_pkg::ST_LOAD) |-> (arrival_count == 6'd0)) else $error("count not wrapped");
`endif

endmodule

// ===== src/jdi_datapath.sv =====
// Datapath for the dequantizing inverse DCT: coefficient store, row-pass store,
// one shared multiply-accumulate and the output stage. Depends on jdi_pkg.
module jdi_datapath #(
  parameter int WEIGHT_FRACTION_BITS = jdi_pkg::WeightFracBitsDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  jdi_pkg::jdi_cmd_t        cmd,
  input  logic signed [11:0]       coefficient,
  input  logic [15:0]              quantizer,
  output logic [7:0]               pixel,
  output logic [5:0]               position,
  output logic                     block_last,
  output logic                     result_valid
);

  localparam int Shift   = 2 * WEIGHT_FRACTION_BITS;
  localparam int RowW    = 48;
  localparam int AccW    = 64;

  logic signed [jdi_pkg::ProductWidth-1:0] coef_mem [64];
  logic signed [RowW-1:0]                  row_mem  [64];

  // Stage 1: operand read and weight lookup.
  logic                    s1_row, s1_col, s1_first, s1_last;
  logic [5:0]              s1_dst;
  logic signed [RowW-1:0]  s1_opnd;
  logic signed [15:0]      s1_w;
  // Stage 2: product.
  logic                    s2_row, s2_col, s2_first, s2_last;
  logic [5:0]              s2_dst;
  logic signed [RowW+15:0] s2_prod;
  // Stage 3: accumulator.
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  acc_next;
  logic signed [AccW-1:0]  biased;

  always_ff @(posedge clk) begin
    if (cmd.store_write) begin
      coef_mem[cmd.store_addr] <= jdi_pkg::ProductWidth'(coefficient) *
                                  jdi_pkg::ProductWidth'($signed({1'b0, quantizer}));
    end
    s1_dst <= cmd.row_mac ? {cmd.idx_a, cmd.idx_b} : {cmd.idx_a, cmd.idx_b};
    if (cmd.row_mac) begin
      s1_opnd <= RowW'(coef_mem[{cmd.idx_a, cmd.idx_k}]);
      s1_w    <= jdi_pkg::weight(cmd.idx_k, cmd.idx_b, WEIGHT_FRACTION_BITS);
    end else begin
      s1_opnd <= row_mem[{cmd.idx_k, cmd.idx_b}];
      s1_w    <= jdi_pkg::weight(cmd.idx_k, cmd.idx_a, WEIGHT_FRACTION_BITS);
    end
    s1_first <= cmd.first;
    s1_last  <= cmd.last;
    s2_prod  <= s1_opnd * s1_w;
    s2_dst   <= s1_dst;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    acc      <= acc_next;
    if (s2_row && s2_last) row_mem[s2_dst] <= RowW'(acc_next);
    if (s2_col && s2_last) begin
      position <= s2_dst;
      if (biased < 0) pixel <= 8'd0;
      else if ((biased >>> Shift) > 255) pixel <= 8'd255;
      else pixel <= 8'(biased >>> Shift);
      block_last <= (s2_dst == 6'd63);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_row <= 1'b0; s1_col <= 1'b0; s2_row <= 1'b0; s2_col <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_row <= cmd.row_mac; s1_col <= cmd.col_mac;
      s2_row <= s1_row;      s2_col <= s1_col;
      result_valid <= s2_col && s2_last;
    end
  end

  always_comb begin
    acc_next = (s2_first ? AccW'(0) : acc) + AccW'(s2_prod);
    biased   = acc_next + (AccW'(128) <<< Shift) + (AccW'(1) <<< (Shift - 1));
  end

`ifndef NO_ASSERTIONS
  a_pixel_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (block_last == (position == 6'd63))) else $error("last flag wrong");
  a_stage_one: assert property (@(posedge clk) disable iff (rst)
    !(s2_row && s2_col)) else $error("row and column op in one stage");
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(s2_col)) else $error("pixel without column op");
`endif

endmodule

// ===== src/jpeg_dequant_idct_8x8.sv =====
// Top level of the dequantizing 8x8 JPEG inverse DCT.
// Depends on jdi_pkg, jdi_ctrl and jdi_datapath.
//
//  Channel   Handshake             Payload
//  request   start / busy          coefficient[11:0] signed, quantizer[15:0]
//  result    result_valid strobe   pixel[7:0], position[5:0], block_last
//
// Each request is taken while busy is low; requests arrive in zigzag
// order and their products are stored at natural positions.
// After the 64th request the block is busy while the row pass and the
// column pass each take 512 multiply-accumulates on one shared multiplier.
// Pixels leave in raster order, each strobed for one cycle; the last one
// appears after busy falls.
// The receiver cannot hold them off. Synchronous reset clears the request count.
module jpeg_dequant_idct_8x8 #(
  parameter int WEIGHT_FRACTION_BITS = jdi_pkg::WeightFracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [11:0] coefficient,
  input  logic [15:0]        quantizer,
  output logic               result_valid,
  output logic [7:0]         pixel,
  output logic [5:0]         position,
  output logic               block_last
);

  jdi_pkg::jdi_cmd_t cmd;

  // Controller: request count, zigzag mapping and the MAC sequence.
  jdi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath: stores, the pipelined MAC and rounding with clamping.
  jdi_datapath #(
    .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .coefficient  (coefficient),
    .quantizer    (quantizer),
    .pixel        (pixel),
    .position     (position),
    .block_last   (block_last),
    .result_valid (result_valid)
  );

`ifndef NO_ASSERTIONS
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && block_last) |-> !busy) else $error("block end while busy");
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !block_last) |-> busy) else $error("pixel outside transform");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ##1 !result_valid) else $error("pixel strobes back to back");
`endif

endmodule
